// ----- hw/rtl/tme_pkg.sv -----
// shared types, constants and decode codes for the tape machine executor
package tme_pkg;

  // default sizes
  localparam int TAPE_ADDR_BITS_DEF = 16;
  localparam int PC_BITS_DEF        = 16;
  localparam int QUEUE_DEPTH        = 2;

  // field widths of the stream payloads
  localparam int OPCODE_W  = 5;
  localparam int OPERAND_W = 16;
  localparam int BYTE_W    = 8;
  localparam int NEXT_PC_W = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_HALT      = 5'd0;
  localparam logic [OPCODE_W-1:0] OP_RIGHT     = 5'd1;
  localparam logic [OPCODE_W-1:0] OP_RIGHT_U8  = 5'd2;
  localparam logic [OPCODE_W-1:0] OP_RIGHT_U16 = 5'd3;
  localparam logic [OPCODE_W-1:0] OP_LEFT      = 5'd4;
  localparam logic [OPCODE_W-1:0] OP_LEFT_U8   = 5'd5;
  localparam logic [OPCODE_W-1:0] OP_LEFT_U16  = 5'd6;
  localparam logic [OPCODE_W-1:0] OP_INC       = 5'd7;
  localparam logic [OPCODE_W-1:0] OP_ADD_B8    = 5'd8;
  localparam logic [OPCODE_W-1:0] OP_DEC       = 5'd9;
  localparam logic [OPCODE_W-1:0] OP_SUB_B8    = 5'd10;
  localparam logic [OPCODE_W-1:0] OP_OUT       = 5'd11;
  localparam logic [OPCODE_W-1:0] OP_IN        = 5'd12;
  localparam logic [OPCODE_W-1:0] OP_BZ_U8     = 5'd13;
  localparam logic [OPCODE_W-1:0] OP_BZ_U16    = 5'd14;
  localparam logic [OPCODE_W-1:0] OP_JNZ_B8    = 5'd15;
  localparam logic [OPCODE_W-1:0] OP_JNZ_B16   = 5'd16;

  // instruction classes handed from front to back
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_NOP  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_HALT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MOVE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ADD  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_OUT  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_IN   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_BZ   = 3'd6;
  localparam logic [KIND_W-1:0] KIND_BNZ  = 3'd7;

  // decoded instruction
  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic                 neg;      // left, dec, sub, or back branch
    logic [OPERAND_W-1:0] amount;   // step, add value or branch offset
    logic [1:0]           len;      // instruction length in bytes
    logic [BYTE_W-1:0]    in_byte;
    logic                 in_eof;
  } tme_item_t;

  localparam int ITEM_W = $bits(tme_item_t);

endpackage

// ----- hw/rtl/tape_machine_bytecode_executor_top.sv -----
// top level of the tape machine bytecode executor
//
// Executes one decoded tape machine instruction per input transfer and returns
// one result transfer per instruction, in order.
// Input channel in_*: opcode, operand, console byte and end-of-input flag.
// Result channel out_*: next pc, branch taken, output strobe and byte, halted.
// The front decodes each transfer into a small queue; the back reads the tape
// cell at the current pointer from a synchronous ram, then executes and writes
// the cell back. Each instruction occupies the back for a ram read state, then
// an execute and write state; the back takes no new instruction from the queue
// until the last one has executed.
// After reset the tape is cleared one cell per cycle, all 2**TAPE_ADDR_BITS
// cells, with in_tready low; pointer, pc and halt flag reset to zero.
// When the receiver stalls, the result register holds its data, the back
// waits, and the queue keeps taking input until it fills.
module tape_machine_bytecode_executor_top
  import tme_pkg::*;
#(
  parameter int TAPE_ADDR_BITS = TAPE_ADDR_BITS_DEF,
  parameter int PC_BITS        = PC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [4:0] opcode, [20:5] operand, [28:21] in_byte, [29] in_eof
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [15:0] next_pc, [16] branch_taken, [17] out_valid, [25:18] out_byte,
  // [26] halted
  output logic [OUT_DATA_W-1:0] out_tdata
);

  tme_item_t push_item, pop_item;
  logic      push, pop, q_full, q_empty, clr_busy;

  tme_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .clr_busy  (clr_busy),
    .push      (push),
    .push_item (push_item)
  );

  tme_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  tme_back #(
    .TAPE_ADDR_BITS (TAPE_ADDR_BITS),
    .PC_BITS        (PC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_item     (pop_item),
    .q_pop      (pop),
    .clr_busy   (clr_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- hw/rtl/tme_ram.sv -----
// generic single write port ram with registered read
module tme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/tme_front.sv -----
// front end: accepts input transfers and decodes them into instruction classes
module tme_front
  import tme_pkg::*;
(
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 q_full,
  input  logic                 clr_busy,
  output logic                 push,
  output tme_item_t            push_item
);

  logic [OPCODE_W-1:0]  opcode;
  logic [OPERAND_W-1:0] operand;
  logic [OPERAND_W-1:0] imm8;

  assign opcode  = in_tdata[4:0];
  assign operand = in_tdata[20:5];
  assign imm8    = {8'b0, operand[7:0]};

  // no transfers while the tape is being cleared
  assign in_tready = !q_full && !clr_busy;
  assign push      = in_tvalid && in_tready;

  // classify the opcode
  always_comb begin
    push_item         = '0;
    push_item.kind    = KIND_NOP;
    push_item.len     = 2'd1;
    push_item.in_byte = in_tdata[28:21];
    push_item.in_eof  = in_tdata[29];
    case (opcode)
      OP_HALT: push_item.kind = KIND_HALT;
      OP_RIGHT, OP_LEFT: begin
        push_item.kind   = KIND_MOVE;
        push_item.amount = 16'd1;
        push_item.neg    = (opcode == OP_LEFT);
      end
      OP_RIGHT_U8, OP_LEFT_U8: begin
        push_item.kind   = KIND_MOVE;
        push_item.amount = imm8;
        push_item.neg    = (opcode == OP_LEFT_U8);
        push_item.len    = 2'd2;
      end
      OP_RIGHT_U16, OP_LEFT_U16: begin
        push_item.kind   = KIND_MOVE;
        push_item.amount = operand;
        push_item.neg    = (opcode == OP_LEFT_U16);
        push_item.len    = 2'd3;
      end
      OP_INC, OP_DEC: begin
        push_item.kind   = KIND_ADD;
        push_item.amount = 16'd1;
        push_item.neg    = (opcode == OP_DEC);
      end
      OP_ADD_B8, OP_SUB_B8: begin
        push_item.kind   = KIND_ADD;
        push_item.amount = imm8;
        push_item.neg    = (opcode == OP_SUB_B8);
        push_item.len    = 2'd2;
      end
      OP_OUT: push_item.kind = KIND_OUT;
      OP_IN:  push_item.kind = KIND_IN;
      OP_BZ_U8: begin
        push_item.kind   = KIND_BZ;
        push_item.amount = imm8;
        push_item.len    = 2'd2;
      end
      OP_BZ_U16: begin
        push_item.kind   = KIND_BZ;
        push_item.amount = operand;
        push_item.len    = 2'd3;
      end
      OP_JNZ_B8: begin
        push_item.kind   = KIND_BNZ;
        push_item.amount = imm8;
        push_item.neg    = 1'b1;
        push_item.len    = 2'd2;
      end
      OP_JNZ_B16: begin
        push_item.kind   = KIND_BNZ;
        push_item.amount = operand;
        push_item.neg    = 1'b1;
        push_item.len    = 2'd3;
      end
      default: push_item.kind = KIND_NOP;
    endcase
  end

endmodule

// ----- hw/rtl/tme_queue.sv -----
// small fifo of decoded instructions between front and back
module tme_queue
  import tme_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tme_item_t push_item,
  input  logic      pop,
  output tme_item_t pop_item,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  tme_item_t        slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;

  assign full     = (count_r == (PTR_W+1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = slots_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- hw/rtl/tme_back.sv -----
// back end: tape clear, cell read, execute and result register
module tme_back
  import tme_pkg::*;
#(
  parameter int TAPE_ADDR_BITS = TAPE_ADDR_BITS_DEF,
  parameter int PC_BITS        = PC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  tme_item_t             q_item,
  output logic                  q_pop,
  output logic                  clr_busy,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int TAB = TAPE_ADDR_BITS;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [TAB-1:0]      clr_addr_r, clr_addr_nxt;
  logic [TAB-1:0]      ptr_r, ptr_nxt;
  logic [PC_BITS-1:0]  pc_r, pc_nxt;
  logic                halt_r, halt_nxt;
  tme_item_t           cur_r;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // tape port signals
  logic                ram_we;
  logic [TAB-1:0]      ram_waddr;
  logic [BYTE_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [BYTE_W-1:0]   cell_rd;

  // execute datapath
  logic                out_free;
  logic                done;
  logic [PC_BITS-1:0]  pc_seq;
  logic [PC_BITS+15:0] pc_fwd_w, pc_back_w;
  logic [TAB+15:0]     ptr_fwd_w, ptr_back_w;
  logic [BYTE_W-1:0]   cell_new;
  logic                taken;
  logic                cell_we;
  logic [PC_BITS+15:0] pc_res_w;
  logic [NEXT_PC_W-1:0] res_pc;
  logic                res_taken, res_ov, res_halt;
  logic [BYTE_W-1:0]   res_ob;

  tme_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (2 ** TAB)
  ) u_tape (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ptr_r),
    .rdata (cell_rd)
  );

  assign clr_busy = (state_r == ST_CLEAR);
  assign out_free = !out_tvalid_r || out_tready;
  assign q_pop    = (state_r == ST_FETCH) && !q_empty;
  assign ram_re   = q_pop;
  assign done     = (state_r == ST_EXEC) && out_free;

  // address and pc arithmetic, all wrapping
  assign pc_seq     = pc_r + PC_BITS'(cur_r.len);
  assign pc_fwd_w   = {16'b0, pc_seq} + {{PC_BITS{1'b0}}, cur_r.amount};
  assign pc_back_w  = {16'b0, pc_seq} - {{PC_BITS{1'b0}}, cur_r.amount};
  assign ptr_fwd_w  = {16'b0, ptr_r} + {{TAB{1'b0}}, cur_r.amount};
  assign ptr_back_w = {16'b0, ptr_r} - {{TAB{1'b0}}, cur_r.amount};

  // instruction execute
  always_comb begin
    ptr_nxt   = ptr_r;
    pc_nxt    = pc_seq;
    halt_nxt  = halt_r;
    cell_new  = cell_rd;
    cell_we   = 1'b0;
    taken     = 1'b0;
    res_ov    = 1'b0;
    res_ob    = '0;
    case (cur_r.kind)
      KIND_HALT: halt_nxt = 1'b1;
      KIND_MOVE: ptr_nxt = cur_r.neg ? ptr_back_w[TAB-1:0] : ptr_fwd_w[TAB-1:0];
      KIND_ADD: begin
        cell_we  = 1'b1;
        cell_new = cur_r.neg ? cell_rd - cur_r.amount[7:0] : cell_rd + cur_r.amount[7:0];
      end
      KIND_OUT: begin
        res_ov = 1'b1;
        res_ob = cell_rd;
      end
      KIND_IN: begin
        cell_we  = 1'b1;
        cell_new = cur_r.in_eof ? '0 : cur_r.in_byte;
      end
      KIND_BZ: begin
        taken = (cell_rd == '0);
        if (taken) pc_nxt = pc_fwd_w[PC_BITS-1:0];
      end
      KIND_BNZ: begin
        taken = (cell_rd != '0);
        if (taken) pc_nxt = pc_back_w[PC_BITS-1:0];
      end
      default: ;
    endcase
    // after halt nothing changes
    if (halt_r) begin
      ptr_nxt  = ptr_r;
      pc_nxt   = pc_r;
      cell_we  = 1'b0;
      taken    = 1'b0;
      res_ov   = 1'b0;
      res_ob   = '0;
    end
  end

  assign pc_res_w  = {16'b0, pc_nxt};
  assign res_pc    = pc_res_w[NEXT_PC_W-1:0];
  assign res_taken = taken;
  assign res_halt  = halt_nxt;

  // tape write port: clear pass or cell update
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = cell_new;
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else if (done && cell_we) begin
      ram_we = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == '1) state_nxt = ST_FETCH;
      end
      ST_FETCH: if (q_pop) state_nxt = ST_EXEC;
      ST_EXEC:  if (out_free) state_nxt = ST_FETCH;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // result register
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (done) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {5'b0, res_halt, res_ob, res_ov, res_taken, res_pc};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      ptr_r        <= '0;
      pc_r         <= '0;
      halt_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (done) begin
        ptr_r  <= ptr_nxt;
        pc_r   <= pc_nxt;
        halt_r <= halt_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_item;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ----- hw/rtl/tme_checker.sv -----
// port-level checks for the tape machine executor, bound to the top level
module tme_checker
  import tme_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // a halted result carries no branch and no output byte
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[26] |->
      !out_tdata[16] && !out_tdata[17] && out_tdata[25:18] == 8'd0)
    else $error("halted result with side effects");

  // output byte is zero without the output strobe, strobe excludes branch
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[17] |-> out_tdata[25:18] == 8'd0)
    else $error("output byte without strobe");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[16] && out_tdata[17]) && out_tdata[31:27] == 5'd0)
    else $error("branch and output strobe together or pad bits set");

endmodule

bind tape_machine_bytecode_executor_top tme_checker u_tme_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
